// File: src/i2cmbe_pkg.sv
// i2cmbe_pkg: shared types and constants for the i2c master byte engine
`default_nettype none

package i2cmbe_pkg;

    // command codes as they arrive on the tick word
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUS_BUSY = 2'd1,
        ST_NO_ACK   = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_ST_CHECK   = 5'd1,
        PH_ST_SCL     = 5'd2,
        PH_ST_END     = 5'd3,
        PH_SP_SDA     = 5'd4,
        PH_SP_SCL     = 5'd5,
        PH_SP_REL     = 5'd6,
        PH_SP_END     = 5'd7,
        PH_WR_SETUP   = 5'd8,
        PH_WR_HIGH    = 5'd9,
        PH_WR_LOW     = 5'd10,
        PH_WR_ACKSET  = 5'd11,
        PH_WR_ACKSAMP = 5'd12,
        PH_RD_PRE     = 5'd13,
        PH_RD_HIGH    = 5'd14,
        PH_RD_LOW     = 5'd15,
        PH_RD_ACKSET  = 5'd16,
        PH_RD_ACKHIGH = 5'd17,
        PH_RD_ACKLOW  = 5'd18
    } t_phase;

    localparam logic [15:0] DELAY_RESET   = 16'd45;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    // one classified tick word as held in the queue
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } t_tick;

    // head of the queue as seen by the sequencer
    typedef struct packed {
        logic  valid;
        t_tick tick;
    } t_q_head;

    // one result word
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        t_status    status;
        logic [7:0] rx_byte;
    } t_result;

endpackage

`default_nettype wire

// File: src/i2cmbe_front.sv
// i2cmbe_front: tick word intake, command classification and two-entry queue
`default_nettype none

module i2cmbe_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  [2:0]           i_command,
    input  wire  [7:0]           i_tx_byte,
    input  wire                  i_send_nack,
    input  wire                  i_sda_in,
    input  wire                  i_pop,
    output i2cmbe_pkg::t_q_head  o_head
);

    i2cmbe_pkg::t_tick r_q0;
    i2cmbe_pkg::t_tick r_q1;
    logic [1:0]        r_cnt;
    i2cmbe_pkg::t_tick w_tick;
    logic              w_push;
    logic              w_pop;

    // unknown codes act as no command
    always_comb begin
        case (i_command)
            i2cmbe_pkg::CMD_START,
            i2cmbe_pkg::CMD_STOP,
            i2cmbe_pkg::CMD_WRITE,
            i2cmbe_pkg::CMD_READ: w_tick.cmd = i2cmbe_pkg::t_cmd'(i_command);
            default:              w_tick.cmd = i2cmbe_pkg::CMD_NONE;
        endcase
        w_tick.tx_byte   = i_tx_byte;
        w_tick.send_nack = i_send_nack;
        w_tick.sda_in    = i_sda_in;
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && (r_cnt == 2'd2)) begin
            r_q0 <= r_q1;
        end else if (w_push && ((r_cnt == 2'd0) || w_pop)) begin
            r_q0 <= w_tick;
        end
        if (w_push && (r_cnt == 2'd1) && !w_pop) begin
            r_q1 <= w_tick;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.tick  = r_q0;

endmodule

`default_nettype wire

// File: src/i2cmbe_back.sv
// i2cmbe_back: bit sequencer and result output register
`default_nettype none

module i2cmbe_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  i2cmbe_pkg::t_q_head  i_head,
    output logic                 o_pop,
    input  wire  [15:0]          i_delay_ticks,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output i2cmbe_pkg::t_result  o_result
);

    i2cmbe_pkg::t_phase  r_phase,  n_phase;
    logic [3:0]          r_bit,    n_bit;
    logic [7:0]          r_shift,  n_shift;
    logic [15:0]         r_wait,   n_wait;
    logic                r_scl,    n_scl;
    logic                r_sda,    n_sda;
    logic                r_nack,   n_nack;
    i2cmbe_pkg::t_status r_status, n_status;
    logic [7:0]          r_rx,     n_rx;
    logic                n_done;
    logic                r_out_valid;
    i2cmbe_pkg::t_result r_out;
    i2cmbe_pkg::t_result w_res;
    logic [15:0]         w_delay;
    logic                w_step;
    i2cmbe_pkg::t_tick   w_tick;

    assign w_delay = (i_delay_ticks == 16'd0) ? 16'd1 : i_delay_ticks;
    assign w_step  = i_head.valid && (!r_out_valid || i_out_ready);
    assign w_tick  = i_head.tick;
    assign o_pop   = w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= i2cmbe_pkg::PH_IDLE;
            r_bit    <= 4'd0;
            r_shift  <= 8'd0;
            r_wait   <= 16'd0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_nack   <= 1'b0;
            r_status <= i2cmbe_pkg::ST_OK;
            r_rx     <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_wait   <= n_wait;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_nack   <= n_nack;
            r_status <= n_status;
            r_rx     <= n_rx;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_wait   = r_wait;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_nack   = r_nack;
        n_status = r_status;
        n_rx     = r_rx;
        n_done   = 1'b0;
        if (w_step) begin
            if (r_phase == i2cmbe_pkg::PH_IDLE) begin
                case (w_tick.cmd)
                    i2cmbe_pkg::CMD_START: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_phase = i2cmbe_pkg::PH_ST_CHECK;
                        n_wait  = w_delay;
                    end
                    i2cmbe_pkg::CMD_STOP: begin
                        n_scl   = 1'b0;
                        n_phase = i2cmbe_pkg::PH_SP_SDA;
                        n_wait  = w_delay;
                    end
                    i2cmbe_pkg::CMD_WRITE: begin
                        n_shift = w_tick.tx_byte;
                        n_bit   = 4'd0;
                        n_sda   = w_tick.tx_byte[7];
                        n_phase = i2cmbe_pkg::PH_WR_SETUP;
                        n_wait  = w_delay;
                    end
                    i2cmbe_pkg::CMD_READ: begin
                        n_shift = 8'd0;
                        n_bit   = 4'd0;
                        n_nack  = w_tick.send_nack;
                        n_phase = i2cmbe_pkg::PH_RD_PRE;
                        n_wait  = w_delay;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end else if (r_wait > 16'd1) begin
                n_wait = r_wait - 16'd1;
            end else begin
                // end of a wait: next line change and the wait after it
                n_wait = w_delay;
                case (r_phase)
                    i2cmbe_pkg::PH_ST_CHECK: begin
                        if (!w_tick.sda_in) begin
                            n_phase  = i2cmbe_pkg::PH_IDLE;
                            n_wait   = 16'd0;
                            n_status = i2cmbe_pkg::ST_BUS_BUSY;
                            n_done   = 1'b1;
                        end else begin
                            n_sda   = 1'b0;
                            n_phase = i2cmbe_pkg::PH_ST_SCL;
                        end
                    end
                    i2cmbe_pkg::PH_ST_SCL: begin
                        n_scl   = 1'b0;
                        n_phase = i2cmbe_pkg::PH_ST_END;
                    end
                    i2cmbe_pkg::PH_SP_SDA: begin
                        n_sda   = 1'b0;
                        n_phase = i2cmbe_pkg::PH_SP_SCL;
                    end
                    i2cmbe_pkg::PH_SP_SCL: begin
                        n_scl   = 1'b1;
                        n_phase = i2cmbe_pkg::PH_SP_REL;
                    end
                    i2cmbe_pkg::PH_SP_REL: begin
                        n_sda   = 1'b1;
                        n_phase = i2cmbe_pkg::PH_SP_END;
                    end
                    i2cmbe_pkg::PH_ST_END,
                    i2cmbe_pkg::PH_SP_END: begin
                        n_phase  = i2cmbe_pkg::PH_IDLE;
                        n_wait   = 16'd0;
                        n_status = i2cmbe_pkg::ST_OK;
                        n_done   = 1'b1;
                    end
                    i2cmbe_pkg::PH_WR_SETUP: begin
                        n_scl   = 1'b1;
                        n_phase = i2cmbe_pkg::PH_WR_HIGH;
                    end
                    i2cmbe_pkg::PH_WR_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = i2cmbe_pkg::PH_WR_LOW;
                    end
                    i2cmbe_pkg::PH_WR_LOW: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = r_bit + 4'd1;
                        if (n_bit < i2cmbe_pkg::BITS_PER_BYTE) begin
                            n_sda   = r_shift[6];
                            n_phase = i2cmbe_pkg::PH_WR_SETUP;
                        end else begin
                            n_sda   = 1'b1;
                            n_phase = i2cmbe_pkg::PH_WR_ACKSET;
                        end
                    end
                    i2cmbe_pkg::PH_WR_ACKSET: begin
                        n_scl   = 1'b1;
                        n_phase = i2cmbe_pkg::PH_WR_ACKSAMP;
                    end
                    i2cmbe_pkg::PH_WR_ACKSAMP: begin
                        // a nak leaves scl high
                        n_phase = i2cmbe_pkg::PH_IDLE;
                        n_wait  = 16'd0;
                        n_done  = 1'b1;
                        if (w_tick.sda_in) begin
                            n_status = i2cmbe_pkg::ST_NO_ACK;
                        end else begin
                            n_scl    = 1'b0;
                            n_status = i2cmbe_pkg::ST_OK;
                        end
                    end
                    i2cmbe_pkg::PH_RD_PRE: begin
                        n_scl   = 1'b1;
                        n_phase = i2cmbe_pkg::PH_RD_HIGH;
                    end
                    i2cmbe_pkg::PH_RD_HIGH: begin
                        n_shift = {r_shift[6:0], w_tick.sda_in};
                        n_scl   = 1'b0;
                        n_phase = i2cmbe_pkg::PH_RD_LOW;
                    end
                    i2cmbe_pkg::PH_RD_LOW: begin
                        n_bit = r_bit + 4'd1;
                        if (n_bit < i2cmbe_pkg::BITS_PER_BYTE) begin
                            n_scl   = 1'b1;
                            n_phase = i2cmbe_pkg::PH_RD_HIGH;
                        end else begin
                            n_sda   = r_nack;
                            n_phase = i2cmbe_pkg::PH_RD_ACKSET;
                        end
                    end
                    i2cmbe_pkg::PH_RD_ACKSET: begin
                        n_scl   = 1'b1;
                        n_phase = i2cmbe_pkg::PH_RD_ACKHIGH;
                    end
                    i2cmbe_pkg::PH_RD_ACKHIGH: begin
                        n_scl   = 1'b0;
                        n_phase = i2cmbe_pkg::PH_RD_ACKLOW;
                    end
                    i2cmbe_pkg::PH_RD_ACKLOW: begin
                        n_sda    = 1'b1;
                        n_rx     = r_shift;
                        n_phase  = i2cmbe_pkg::PH_IDLE;
                        n_wait   = 16'd0;
                        n_status = i2cmbe_pkg::ST_OK;
                        n_done   = 1'b1;
                    end
                    default: begin
                        n_phase = i2cmbe_pkg::PH_IDLE;
                        n_wait  = 16'd0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        w_res.scl_out  = n_scl;
        w_res.sda_out  = n_sda;
        w_res.busy_res = (n_phase != i2cmbe_pkg::PH_IDLE);
        w_res.done_res = n_done;
        w_res.status   = n_status;
        w_res.rx_byte  = n_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// File: src/i2c_master_byte_engine.sv
// i2c_master_byte_engine: top level of the tick-driven i2c master byte engine
//
// usage:
//   - input channel (i_in_valid / o_in_ready): one word per base tick, with the
//     command, the byte to send, the ack choice for reads and the sampled sda
//   - output channel (o_out_valid / i_out_ready): exactly one result word per
//     input word, in order: scl and sda levels, busy, done pulse, status, rx byte
//   - config channel (i_cfg_valid / o_cfg_ready): writes delay_ticks, always
//     ready; write it only while no words are in flight
//   - throughput: one word per cycle sustained while each result is taken at
//     once; the sequencer does one tick of work per cycle unless stalled, and the
//     two-entry queue plus output register keep both sides streaming
//   - path: an accepted input word is written into the queue, and its result
//     word is then registered in the output register
//   - receiver stall: the result is held in the output register, the queue
//     absorbs two more words, then o_in_ready drops until the result is taken
//   - reset: queue and output register empty, lines released, phase idle,
//     status ok, rx byte zero, delay_ticks 45
`default_nettype none

module i2c_master_byte_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // tick words
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_command,
    input  wire  [7:0]  i_tx_byte,
    input  wire         i_send_nack,
    input  wire         i_sda_in,
    // result words
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [7:0]  o_rx_byte,
    // delay_ticks write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_data
);

    logic [15:0]         r_delay_ticks;
    i2cmbe_pkg::t_q_head w_head;
    logic                w_pop;
    i2cmbe_pkg::t_result w_result;

    // per-phase wait length, zero is treated as one by the sequencer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ticks <= i2cmbe_pkg::DELAY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_delay_ticks <= i_cfg_data;
        end
    end

    // intake and classification
    i2cmbe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_tx_byte   (i_tx_byte),
        .i_send_nack (i_send_nack),
        .i_sda_in    (i_sda_in),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    // bit sequencer, one queued tick per cycle unless the result output is stalled
    i2cmbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_delay_ticks (r_delay_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (w_result)
    );

    assign o_scl_out  = w_result.scl_out;
    assign o_sda_out  = w_result.sda_out;
    assign o_busy_res = w_result.busy_res;
    assign o_done_res = w_result.done_res;
    assign o_status   = w_result.status;
    assign o_rx_byte  = w_result.rx_byte;

endmodule

`default_nettype wire

// File: src/i2cmbe_chk.sv
// i2cmbe_chk: port-level assertions for the i2c master byte engine, with bind
`default_nettype none

module i2cmbe_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire [2:0]  i_command,
    input wire [7:0]  i_tx_byte,
    input wire        i_send_nack,
    input wire        i_sda_in,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_scl_out,
    input wire        o_sda_out,
    input wire        o_busy_res,
    input wire        o_done_res,
    input wire [1:0]  o_status,
    input wire [7:0]  o_rx_byte,
    input wire        i_cfg_valid,
    input wire        o_cfg_ready,
    input wire [15:0] i_cfg_data
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_scl_out) && $stable(o_sda_out) && $stable(o_busy_res)
            && $stable(o_done_res) && $stable(o_status) && $stable(o_rx_byte))
        else $error("result word changed while stalled");

    // the finishing tick leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    // status code is always one of the three defined values
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == i2cmbe_pkg::ST_OK)
            || (o_status == i2cmbe_pkg::ST_BUS_BUSY)
            || (o_status == i2cmbe_pkg::ST_NO_ACK))
        else $error("undefined status code");

    // a bus-busy start finishes with both lines released
    a_busy_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res && (o_status == i2cmbe_pkg::ST_BUS_BUSY)
            |-> o_scl_out && o_sda_out)
        else $error("lines not released after bus-busy start");

endmodule

bind i2c_master_byte_engine i2cmbe_chk u_i2cmbe_chk (.*);

`default_nettype wire

// File: sim/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// self-checking testbench for the tick-driven i2c master byte engine

module tb_i2c_master_byte_engine;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PRINT_CAP   = 40;
    localparam int IDLE_PCT    = 36;

    // command codes outside the defined set, the engine treats them as none
    localparam logic [2:0] CMD_RSVD_A = 3'd5;
    localparam logic [2:0] CMD_RSVD_B = 3'd6;
    localparam logic [2:0] CMD_RSVD_C = 3'd7;

    // one tick word as it waits in the driver queue
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx;
        logic       nack;
        logic       sda;
    } t_tick_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_command;
    logic [7:0]  i_tx_byte;
    logic        i_send_nack;
    logic        i_sda_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_scl_out;
    logic        o_sda_out;
    logic        o_busy_res;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic [7:0]  o_rx_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    i2c_master_byte_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_tx_byte   (i_tx_byte),
        .i_send_nack (i_send_nack),
        .i_sda_in    (i_sda_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_scl_out   (o_scl_out),
        .o_sda_out   (o_sda_out),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_status    (o_status),
        .o_rx_byte   (o_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // tick words waiting for the driver, and line results still to arrive
    t_tick_word          pending_ticks[$];
    i2cmbe_pkg::t_result line_results_q[$];

    int unsigned cyc_count;
    int unsigned err_count;
    int unsigned result_idx;
    int unsigned gen_ticks;
    logic [15:0] gen_delay;
    logic        sender_hold;
    logic        in_took;

    // shadow engine: phase sequencer, shifter, line levels and sticky outputs
    i2cmbe_pkg::t_phase  eng_phase;
    logic [3:0]          eng_bits;
    logic [7:0]          eng_shift;
    logic [15:0]         eng_wait_cnt;
    logic [15:0]         eng_delay;
    logic                eng_scl;
    logic                eng_sda;
    logic                eng_nack;
    logic                eng_done;
    i2cmbe_pkg::t_status eng_status;
    logic [7:0]          eng_rx;

    // finished-command tallies for the summary
    int unsigned n_finished;
    int unsigned n_bus_busy;
    int unsigned n_no_ack;
    int unsigned n_reads;

    task automatic engine_reset();
        eng_phase    = i2cmbe_pkg::PH_IDLE;
        eng_bits     = '0;
        eng_shift    = '0;
        eng_wait_cnt = '0;
        eng_delay    = i2cmbe_pkg::DELAY_RESET;
        eng_scl      = 1'b1;
        eng_sda      = 1'b1;
        eng_nack     = 1'b0;
        eng_done     = 1'b0;
        eng_status   = i2cmbe_pkg::ST_OK;
        eng_rx       = '0;
    endtask

    // enter a phase wait, a zero delay behaves as one tick
    task automatic go_wait(input i2cmbe_pkg::t_phase nxt);
        eng_phase    = nxt;
        eng_wait_cnt = (eng_delay == 16'd0) ? 16'd1 : eng_delay;
    endtask

    task automatic finish_cmd(input i2cmbe_pkg::t_status st);
        eng_phase    = i2cmbe_pkg::PH_IDLE;
        eng_wait_cnt = '0;
        eng_status   = st;
        eng_done     = 1'b1;
        n_finished++;
        if (st == i2cmbe_pkg::ST_BUS_BUSY) n_bus_busy++;
        if (st == i2cmbe_pkg::ST_NO_ACK) n_no_ack++;
    endtask

    // one base tick of the engine, returns the line result it produces
    task automatic engine_tick(input t_tick_word w, output i2cmbe_pkg::t_result r);
        eng_done = 1'b0;
        if (eng_phase == i2cmbe_pkg::PH_IDLE) begin
            // commands only land while idle, anything else is dropped
            case (w.cmd)
                i2cmbe_pkg::CMD_START: begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                    go_wait(i2cmbe_pkg::PH_ST_CHECK);
                end
                i2cmbe_pkg::CMD_STOP: begin
                    eng_scl = 1'b0;
                    go_wait(i2cmbe_pkg::PH_SP_SDA);
                end
                i2cmbe_pkg::CMD_WRITE: begin
                    eng_shift = w.tx;
                    eng_bits  = '0;
                    eng_sda   = w.tx[7];
                    go_wait(i2cmbe_pkg::PH_WR_SETUP);
                end
                i2cmbe_pkg::CMD_READ: begin
                    eng_shift = '0;
                    eng_bits  = '0;
                    eng_nack  = w.nack;
                    go_wait(i2cmbe_pkg::PH_RD_PRE);
                end
                default: ;
            endcase
        end else if (eng_wait_cnt > 16'd1) begin
            eng_wait_cnt = eng_wait_cnt - 16'd1;
        end else begin
            case (eng_phase)
                i2cmbe_pkg::PH_ST_CHECK: begin
                    // sda held low by someone else while both lines released
                    if (!w.sda) begin
                        finish_cmd(i2cmbe_pkg::ST_BUS_BUSY);
                    end else begin
                        eng_sda = 1'b0;
                        go_wait(i2cmbe_pkg::PH_ST_SCL);
                    end
                end
                i2cmbe_pkg::PH_ST_SCL: begin
                    eng_scl = 1'b0;
                    go_wait(i2cmbe_pkg::PH_ST_END);
                end
                i2cmbe_pkg::PH_ST_END:   finish_cmd(i2cmbe_pkg::ST_OK);
                i2cmbe_pkg::PH_SP_SDA: begin
                    eng_sda = 1'b0;
                    go_wait(i2cmbe_pkg::PH_SP_SCL);
                end
                i2cmbe_pkg::PH_SP_SCL: begin
                    eng_scl = 1'b1;
                    go_wait(i2cmbe_pkg::PH_SP_REL);
                end
                i2cmbe_pkg::PH_SP_REL: begin
                    eng_sda = 1'b1;
                    go_wait(i2cmbe_pkg::PH_SP_END);
                end
                i2cmbe_pkg::PH_SP_END:   finish_cmd(i2cmbe_pkg::ST_OK);
                i2cmbe_pkg::PH_WR_SETUP: begin
                    eng_scl = 1'b1;
                    go_wait(i2cmbe_pkg::PH_WR_HIGH);
                end
                i2cmbe_pkg::PH_WR_HIGH: begin
                    eng_scl = 1'b0;
                    go_wait(i2cmbe_pkg::PH_WR_LOW);
                end
                i2cmbe_pkg::PH_WR_LOW: begin
                    eng_shift = eng_shift << 1;
                    eng_bits  = eng_bits + 4'd1;
                    if (eng_bits < i2cmbe_pkg::BITS_PER_BYTE) begin
                        eng_sda = eng_shift[7];
                        go_wait(i2cmbe_pkg::PH_WR_SETUP);
                    end else begin
                        // release sda for the slave ack
                        eng_sda = 1'b1;
                        go_wait(i2cmbe_pkg::PH_WR_ACKSET);
                    end
                end
                i2cmbe_pkg::PH_WR_ACKSET: begin
                    eng_scl = 1'b1;
                    go_wait(i2cmbe_pkg::PH_WR_ACKSAMP);
                end
                i2cmbe_pkg::PH_WR_ACKSAMP: begin
                    // on a nak scl stays high
                    if (w.sda) begin
                        finish_cmd(i2cmbe_pkg::ST_NO_ACK);
                    end else begin
                        eng_scl = 1'b0;
                        finish_cmd(i2cmbe_pkg::ST_OK);
                    end
                end
                i2cmbe_pkg::PH_RD_PRE: begin
                    eng_scl = 1'b1;
                    go_wait(i2cmbe_pkg::PH_RD_HIGH);
                end
                i2cmbe_pkg::PH_RD_HIGH: begin
                    eng_shift = {eng_shift[6:0], w.sda};
                    eng_scl   = 1'b0;
                    go_wait(i2cmbe_pkg::PH_RD_LOW);
                end
                i2cmbe_pkg::PH_RD_LOW: begin
                    eng_bits = eng_bits + 4'd1;
                    if (eng_bits < i2cmbe_pkg::BITS_PER_BYTE) begin
                        eng_scl = 1'b1;
                        go_wait(i2cmbe_pkg::PH_RD_HIGH);
                    end else begin
                        eng_sda = eng_nack;
                        go_wait(i2cmbe_pkg::PH_RD_ACKSET);
                    end
                end
                i2cmbe_pkg::PH_RD_ACKSET: begin
                    eng_scl = 1'b1;
                    go_wait(i2cmbe_pkg::PH_RD_ACKHIGH);
                end
                i2cmbe_pkg::PH_RD_ACKHIGH: begin
                    eng_scl = 1'b0;
                    go_wait(i2cmbe_pkg::PH_RD_ACKLOW);
                end
                i2cmbe_pkg::PH_RD_ACKLOW: begin
                    eng_sda = 1'b1;
                    eng_rx  = eng_shift;
                    n_reads++;
                    finish_cmd(i2cmbe_pkg::ST_OK);
                end
                default: begin
                    eng_phase    = i2cmbe_pkg::PH_IDLE;
                    eng_wait_cnt = '0;
                end
            endcase
        end
        r.scl_out  = eng_scl;
        r.sda_out  = eng_sda;
        r.busy_res = (eng_phase != i2cmbe_pkg::PH_IDLE);
        r.done_res = eng_done;
        r.status   = eng_status;
        r.rx_byte  = eng_rx;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     result_idx, what, got, want);
        err_count++;
    endtask

    // monitor: checks result words, tracks config writes, predicts each tick
    always @(posedge i_clk) begin : monitor
        i2cmbe_pkg::t_result want;
        i2cmbe_pkg::t_result pred;
        t_tick_word          taken;
        cyc_count++;
        if (!i_rst_n) begin
            engine_reset();
            in_took = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (line_results_q.size() == 0) begin
                    report_mismatch("result word with nothing pending", 16'd1, 16'd0);
                end else begin
                    want = line_results_q.pop_front();
                    if (o_scl_out !== want.scl_out)
                        report_mismatch("scl_out", o_scl_out, want.scl_out);
                    if (o_sda_out !== want.sda_out)
                        report_mismatch("sda_out", o_sda_out, want.sda_out);
                    if (o_busy_res !== want.busy_res)
                        report_mismatch("busy_res", o_busy_res, want.busy_res);
                    if (o_done_res !== want.done_res)
                        report_mismatch("done_res", o_done_res, want.done_res);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", o_rx_byte, want.rx_byte);
                end
                result_idx++;
            end
            if (i_cfg_valid && o_cfg_ready)
                eng_delay = i_cfg_data;
            in_took = i_in_valid && o_in_ready;
            if (in_took) begin
                taken.cmd  = i_command;
                taken.tx   = i_tx_byte;
                taken.nack = i_send_nack;
                taken.sda  = i_sda_in;
                engine_tick(taken, pred);
                line_results_q.push_back(pred);
            end
        end
    end

    // driver: presents queued tick words and throttles the result side
    always @(negedge i_clk) begin : driver
        t_tick_word w;
        int         idle_pct;
        // a long stretch early on runs with both sides streaming
        idle_pct = (cyc_count >= 800 && cyc_count < 2800) ? 0 : IDLE_PCT;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            // a word that is up but not yet taken stays as it is
            if (!i_in_valid || in_took) begin
                if (pending_ticks.size() != 0 && !sender_hold &&
                    $urandom_range(0, 99) >= idle_pct) begin
                    w = pending_ticks.pop_front();
                    i_in_valid  <= 1'b1;
                    i_command   <= w.cmd;
                    i_tx_byte   <= w.tx;
                    i_send_nack <= w.nack;
                    i_sda_in    <= w.sda;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic push_word(input logic [2:0] cmd, input logic [7:0] tx,
                             input logic nack, input logic sda);
        t_tick_word w;
        w.cmd  = cmd;
        w.tx   = tx;
        w.nack = nack;
        w.sda  = sda;
        pending_ticks.push_back(w);
        gen_ticks++;
    endtask

    // one command word followed by exactly the ticks the command needs
    task automatic add_txn(input i2cmbe_pkg::t_cmd cmd, input logic [7:0] tx,
                           input logic nack, input int sda_pct, input int noise_pct);
        int unsigned eff;
        int unsigned fill;
        logic [2:0]  filler_cmd;
        eff = (gen_delay == 16'd0) ? 1 : gen_delay;
        case (cmd)
            i2cmbe_pkg::CMD_START: fill = (sda_pct == 0) ? eff : 3 * eff;
            i2cmbe_pkg::CMD_STOP:  fill = 4 * eff;
            i2cmbe_pkg::CMD_WRITE: fill = 26 * eff;
            i2cmbe_pkg::CMD_READ:  fill = 20 * eff;
            default:               fill = 0;
        endcase
        push_word(cmd, tx, nack, chance(sda_pct));
        repeat (fill) begin
            // noise commands land while busy and must be dropped
            filler_cmd = chance(noise_pct)
                ? 3'($urandom_range(i2cmbe_pkg::CMD_NONE, CMD_RSVD_C))
                : i2cmbe_pkg::CMD_NONE;
            push_word(filler_cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      chance(sda_pct));
        end
    endtask

    task automatic run_random(input int unsigned target, input int noise_pct);
        int unsigned start_cnt;
        int unsigned pick;
        logic [2:0]  idle_cmd;
        start_cnt = gen_ticks;
        while (gen_ticks - start_cnt < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                add_txn(i2cmbe_pkg::CMD_START, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 85, noise_pct);
            else if (pick < 50)
                add_txn(i2cmbe_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 35, noise_pct);
            else if (pick < 75)
                add_txn(i2cmbe_pkg::CMD_READ, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 50, noise_pct);
            else if (pick < 90)
                add_txn(i2cmbe_pkg::CMD_STOP, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 50, noise_pct);
            else begin
                // idle gap, sometimes with an undefined code
                repeat ($urandom_range(1, 3)) begin
                    idle_cmd = chance(50) ? i2cmbe_pkg::CMD_NONE
                                          : 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
                    push_word(idle_cmd, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), chance(50));
                end
            end
        end
    endtask

    // look just after the falling edge so the driver's update is visible
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_ticks.size() != 0 || i_in_valid ||
                   line_results_q.size() != 0);
    endtask

    // drain everything and make sure the engine has gone back to idle
    task automatic settle_engine();
        wait_drained();
        while (eng_phase != i2cmbe_pkg::PH_IDLE) begin
            repeat (32) push_word(i2cmbe_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1);
            wait_drained();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_delay(input logic [15:0] value);
        settle_engine();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_delay = value;
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] mid_delay;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = i2cmbe_pkg::CMD_NONE;
        i_tx_byte   = '0;
        i_send_nack = 1'b0;
        i_sda_in    = 1'b1;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        sender_hold = 1'b0;
        in_took     = 1'b0;
        cyc_count   = 0;
        err_count   = 0;
        result_idx  = 0;
        gen_ticks   = 0;
        n_finished  = 0;
        n_bus_busy  = 0;
        n_no_ack    = 0;
        n_reads     = 0;
        gen_delay   = i2cmbe_pkg::DELAY_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset delay of 45 ticks per phase
        add_txn(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 100, 0);
        add_txn(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 50, 0);

        // directed: one tick per phase
        set_delay(16'd1);
        add_txn(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 100, 0);
        add_txn(i2cmbe_pkg::CMD_WRITE, 8'hFF, 1'b0, 0, 0);    // all ones, acked
        add_txn(i2cmbe_pkg::CMD_WRITE, 8'h00, 1'b0, 100, 0);  // nak leaves scl high
        add_txn(i2cmbe_pkg::CMD_WRITE, 8'hA5, 1'b1, 0, 0);
        add_txn(i2cmbe_pkg::CMD_READ, 8'h00, 1'b1, 100, 0);   // reads 0xff, sends nack
        add_txn(i2cmbe_pkg::CMD_READ, 8'hFF, 1'b0, 0, 0);     // reads 0x00, sends ack
        add_txn(i2cmbe_pkg::CMD_READ, 8'h3C, 1'b0, 50, 0);
        add_txn(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 50, 0);
        add_txn(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 0, 0);    // bus held low, refused
        push_word(CMD_RSVD_A, 8'hFF, 1'b1, 1'b0);
        push_word(CMD_RSVD_B, 8'h00, 1'b0, 1'b1);
        push_word(CMD_RSVD_C, 8'h81, 1'b1, 1'b1);
        add_txn(i2cmbe_pkg::CMD_WRITE, 8'h5A, 1'b0, 35, 100); // commands during busy
        add_txn(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 50, 100);

        // zero delay behaves like one
        set_delay(16'd0);
        add_txn(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 100, 0);
        add_txn(i2cmbe_pkg::CMD_WRITE, 8'hC3, 1'b0, 50, 0);
        add_txn(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 50, 0);
        run_random(80, 10);

        set_delay(16'd1);
        run_random(120, 10);

        // hold the sender midway until every result is back
        set_delay(16'd2);
        run_random(120, 10);
        do @(negedge i_clk);
        while (pending_ticks.size() > 60);
        sender_hold = 1'b1;
        do @(negedge i_clk);
        while (i_in_valid || line_results_q.size() != 0);
        sender_hold = 1'b0;

        mid_delay = 16'($urandom_range(3, 6));
        set_delay(mid_delay);
        run_random(80, 10);

        set_delay(16'd1);
        run_random(40, 0);
        settle_engine();
        repeat (10) @(posedge i_clk);

        $display("%0d ticks checked over delays 45, 0, 1, 2 and %0d",
                 result_idx, mid_delay);
        $display("%0d commands finished: %0d refused at start, %0d not acked, %0d reads",
                 n_finished, n_bus_busy, n_no_ack, n_reads);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
